// ----- hdl/mm_pkg.sv -----
// Shared types, sizes and helpers for the matrix multiply block.
// No dependencies; every other file of the block depends on this package.
package mm_pkg;

  // Size of the element stores and the bound on any one dimension
  localparam int MAX_DIM     = 8;
  localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths of the channels
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 6;
  localparam int ELEM_W    = 16;
  localparam int SUM_W     = 40;
  localparam int POS_W     = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Internal widths
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int COL_W     = $clog2(DIM_CAP);
  localparam int CNT_W     = $clog2(DIM_CAP + 1);
  // Length of the wait after the last read issue: it covers the read and multiply
  // stages and the chain of DIM_CAP cells, with a margin on top
  localparam int FLUSH_LEN = DIM_CAP + 3;
  localparam int FLUSH_W   = $clog2(FLUSH_LEN + 1);

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START      = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LHS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_RHS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPUTE,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  // Store write from the command decoder
  typedef struct packed {
    logic                     left_en;
    logic                     right_en;
    logic [ADDR_W-1:0]        addr;
    logic [ELEM_W-1:0]        data;
  } wr_t;

  // Operand read request for one product
  typedef struct packed {
    logic                     valid;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic [COL_W-1:0]         col;
  } issue_t;

  // Product travelling up the cell chain
  typedef struct packed {
    logic                     valid;
    logic [COL_W-1:0]         col;
    logic signed [PROD_W-1:0] prod;
  } token_t;

  // Broadcast control for the cells
  typedef struct packed {
    logic                     clear;
    logic                     shift;
  } cell_ctrl_t;

  // Map a dimension register onto the range 1 .. DIM_CAP
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > DIM_CAP) begin
      r = CNT_W'(DIM_CAP);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- hdl/mm_if.sv -----
// Channel interfaces of the matrix multiply block: command, result, config.
// Depends on mm_pkg for field widths.

interface mm_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [mm_pkg::KIND_W-1:0]           kind;
  logic [mm_pkg::INDEX_W-1:0]          element_index;
  logic signed [mm_pkg::ELEM_W-1:0]    element_value;

  modport source(output valid, kind, element_index, element_value, input ready);
  modport sink(input valid, kind, element_index, element_value, output ready);
endinterface

interface mm_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [mm_pkg::SUM_W-1:0]     product_value;
  logic [mm_pkg::POS_W-1:0]            result_row;
  logic [mm_pkg::POS_W-1:0]            result_col;
  logic                                last_element;

  modport source(output valid, product_value, result_row, result_col, last_element,
                 input ready);
  modport sink(input valid, product_value, result_row, result_col, last_element,
               output ready);
endinterface

interface mm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mm_pkg::CFG_IDX_W-1:0]        index;
  logic [mm_pkg::DIM_W-1:0]            data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/mm_cell.sv -----
// One cell of the accumulator chain: owns one result column of the current row.
// Depends on mm_pkg for token and control types.
module mm_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mm_pkg::COL_W-1:0]        col_id,
  input  mm_pkg::cell_ctrl_t              ctrl,
  input  mm_pkg::token_t                  tok_in,
  output mm_pkg::token_t                  tok_out,
  input  logic signed [mm_pkg::SUM_W-1:0] sum_in,
  output logic signed [mm_pkg::SUM_W-1:0] sum_out
);
  import mm_pkg::*;

  logic                     tok_valid;
  logic [COL_W-1:0]         tok_col;
  logic signed [PROD_W-1:0] tok_prod;
  logic signed [SUM_W-1:0]  acc;

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_col  <= tok_in.col;
    tok_prod <= tok_in.prod;
  end

  assign tok_out = '{valid: tok_valid, col: tok_col, prod: tok_prod};

  // Clear, take the sum from above while draining, or add a product of this column
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.shift) begin
      acc <= sum_in;
    end else if (tok_in.valid && (tok_in.col == col_id)) begin
      acc <= acc + SUM_W'(tok_in.prod);
    end
  end

  assign sum_out = acc;

endmodule

// ----- hdl/mm_feed.sv -----
// Element stores of both matrices, operand read and product stage.
// Depends on mm_pkg; feeds the first cell of the chain.
module mm_feed (
  input  logic           clk,
  input  logic           rst,
  input  mm_pkg::wr_t    wr,
  input  mm_pkg::issue_t issue,
  output mm_pkg::token_t tok
);
  import mm_pkg::*;

  logic [ELEM_W-1:0] left_mem  [STORE_DEPTH];
  logic [ELEM_W-1:0] right_mem [STORE_DEPTH];

  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic                     rd_valid;
  logic [COL_W-1:0]         rd_col;

  logic                     prod_valid;
  logic [COL_W-1:0]         prod_col;
  logic signed [PROD_W-1:0] prod;

  // Store writes from load commands
  always_ff @(posedge clk) begin
    if (wr.left_en) begin
      left_mem[wr.addr] <= wr.data;
    end
    if (wr.right_en) begin
      right_mem[wr.addr] <= wr.data;
    end
  end

  // Registered operand reads
  always_ff @(posedge clk) begin
    a_q    <= left_mem[issue.addr_a];
    b_q    <= right_mem[issue.addr_b];
    rd_col <= issue.col;
  end

  // Multiply the operand pair
  always_ff @(posedge clk) begin
    prod     <= a_q * b_q;
    prod_col <= rd_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= issue.valid;
      prod_valid <= rd_valid;
    end
  end

  assign tok = '{valid: prod_valid, col: prod_col, prod: prod};

endmodule

// ----- hdl/mm_ctrl.sv -----
// Sequencer: config registers, command decode, read issue order, drain and
// the result register. Depends on mm_pkg and the channel interfaces.
module mm_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  mm_cmd_if.sink                          cmd,
  mm_res_if.source                        result,
  mm_cfg_if.sink                          cfg,
  input  logic signed [mm_pkg::SUM_W-1:0] sum_head,
  output mm_pkg::wr_t                     wr,
  output mm_pkg::issue_t                  issue,
  output mm_pkg::cell_ctrl_t              cell_ctrl
);
  import mm_pkg::*;

  state_t state;
  state_t state_next;

  logic [DIM_W-1:0]   rows_lhs;
  logic [DIM_W-1:0]   inner_dim;
  logic [DIM_W-1:0]   cols_rhs;

  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   p_eff;
  logic [CNT_W-1:0]   m_eff;
  logic [CNT_W-1:0]   i_cnt;
  logic [CNT_W-1:0]   j_cnt;
  logic [CNT_W-1:0]   k_cnt;
  logic [ADDR_W-1:0]  base_a;
  logic [ADDR_W-1:0]  row_b;
  logic [FLUSH_W-1:0] flush_cnt;

  logic               out_valid;
  logic signed [SUM_W-1:0] out_value;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;
  logic               out_last;

  logic cmd_xfer;
  logic start;
  logic j_last;
  logic k_last;
  logic i_last;
  logic flush_done;
  logic in_range;
  logic issue_valid;

  assign cmd_xfer   = cmd.valid && cmd.ready;
  assign start      = cmd_xfer && (cmd.kind == KIND_START);
  assign j_last     = (j_cnt == m_eff - CNT_W'(1));
  assign k_last     = (k_cnt == p_eff - CNT_W'(1));
  assign i_last     = (i_cnt == n_eff - CNT_W'(1));
  assign flush_done = (flush_cnt == FLUSH_W'(FLUSH_LEN - 1));
  assign in_range   = (cmd.element_index < STORE_DEPTH);

  // Configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_lhs  <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_rhs  <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ROWS_LHS:  rows_lhs  <= cfg.data;
        CFG_INNER_DIM: inner_dim <= cfg.data;
        CFG_COLS_RHS:  cols_rhs  <= cfg.data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_COMPUTE;
      end
      ST_COMPUTE: begin
        if (j_last && k_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (flush_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cell_ctrl.shift && j_last) begin
          state_next = i_last ? ST_IDLE : ST_COMPUTE;
        end
      end
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    cmd.ready       = 1'b0;
    issue_valid     = 1'b0;
    cell_ctrl.clear = 1'b0;
    cell_ctrl.shift = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready       = 1'b1;
        cell_ctrl.clear = 1'b1;
      end
      ST_COMPUTE: begin
        issue_valid = 1'b1;
      end
      ST_FLUSH: ;
      ST_DRAIN: begin
        cell_ctrl.shift = !out_valid || result.ready;
      end
    endcase
  end

  // Read addresses: A[i][k] at i*p + k, B[k][j] at k*m + j
  assign issue.valid  = issue_valid;
  assign issue.addr_a = base_a + ADDR_W'(k_cnt);
  assign issue.addr_b = row_b + ADDR_W'(j_cnt);
  assign issue.col    = COL_W'(j_cnt);

  // Store writes from load commands; out-of-range loads and unknown kinds drop
  assign wr.left_en  = cmd_xfer && (cmd.kind == KIND_LOAD_LEFT) && in_range;
  assign wr.right_en = cmd_xfer && (cmd.kind == KIND_LOAD_RIGHT) && in_range;
  assign wr.addr     = ADDR_W'(cmd.element_index);
  assign wr.data     = cmd.element_value;

  // Loop counters and running addresses
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          n_eff  <= clamp_dim(rows_lhs);
          p_eff  <= clamp_dim(inner_dim);
          m_eff  <= clamp_dim(cols_rhs);
          i_cnt  <= '0;
          j_cnt  <= '0;
          k_cnt  <= '0;
          base_a <= '0;
          row_b  <= '0;
        end
      end
      ST_COMPUTE: begin
        if (j_last) begin
          j_cnt <= '0;
          if (k_last) begin
            k_cnt     <= '0;
            row_b     <= '0;
            flush_cnt <= '0;
          end else begin
            k_cnt <= k_cnt + CNT_W'(1);
            row_b <= row_b + ADDR_W'(m_eff);
          end
        end else begin
          j_cnt <= j_cnt + CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        flush_cnt <= flush_cnt + FLUSH_W'(1);
      end
      ST_DRAIN: begin
        if (cell_ctrl.shift) begin
          if (j_last) begin
            j_cnt  <= '0;
            i_cnt  <= i_cnt + CNT_W'(1);
            base_a <= base_a + ADDR_W'(p_eff);
          end else begin
            j_cnt <= j_cnt + CNT_W'(1);
          end
        end
      end
    endcase
  end

  // Result register: load from the bottom cell, hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cell_ctrl.shift) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ctrl.shift) begin
      out_value <= sum_head;
      out_row   <= POS_W'(i_cnt);
      out_col   <= POS_W'(j_cnt);
      out_last  <= i_last && j_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.product_value = out_value;
  assign result.result_row    = out_row;
  assign result.result_col    = out_col;
  assign result.last_element  = out_last;

endmodule

// ----- hdl/matrix_multiply.sv -----
// Matrix multiply C = A x B on a chain of column accumulator cells.
// Depends on mm_pkg, the channel interfaces, mm_ctrl, mm_feed and mm_cell.
//
// Load commands write one element of A or B; while the block is idle they
// stream at one per cycle. A start command computes C row by row: for each
// row the sequencer reads one A/B operand pair per cycle (bound by the single
// read port of each element store and the one multiplier), waits in a flush
// state for the products to settle in the chain of DIM_CAP cells (DIM_CAP is
// the smaller of MAX_DIM and 8), then shifts the m sums of the row out
// through the result register. A start occupies the block until the last sum
// of C has been shifted into the result register, and no command is taken
// meanwhile; configuration writes are taken at any time. The stores are not
// cleared after reset: read only elements that have been loaded.
module matrix_multiply (
  input  logic      clk,
  input  logic      rst,
  mm_cmd_if.sink    cmd,
  mm_res_if.source  result,
  mm_cfg_if.sink    cfg
);
  import mm_pkg::*;

  wr_t                     wr;
  issue_t                  issue;
  cell_ctrl_t              cell_ctrl;
  token_t                  tok  [DIM_CAP];
  logic signed [SUM_W-1:0] sums [DIM_CAP];

  mm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .result    (result),
    .cfg       (cfg),
    .sum_head  (sums[0]),
    .wr        (wr),
    .issue     (issue),
    .cell_ctrl (cell_ctrl)
  );

  mm_feed u_feed (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .issue (issue),
    .tok   (tok[0])
  );

  // Products travel up the chain, sums drain down toward cell zero
  for (genvar c = 0; c < DIM_CAP; c++) begin : g_cell
    if (c == DIM_CAP - 1) begin : g_top
      mm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .col_id  (COL_W'(c)),
        .ctrl    (cell_ctrl),
        .tok_in  (tok[c]),
        .tok_out (),
        .sum_in  ('0),
        .sum_out (sums[c])
      );
    end else begin : g_mid
      mm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .col_id  (COL_W'(c)),
        .ctrl    (cell_ctrl),
        .tok_in  (tok[c]),
        .tok_out (tok[c+1]),
        .sum_in  (sums[c+1]),
        .sum_out (sums[c])
      );
    end
  end

  // No product may enter the chain while it drains
  a_no_tok_drain: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid |-> !cell_ctrl.shift)
    else $error("product reached the chain while draining");

  // Commands are only taken with no product entering the chain
  a_no_tok_idle: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid |-> !cmd.ready)
    else $error("product in flight while taking commands");

  // A new result appears only after a drain shift
  a_res_from_shift: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cell_ctrl.shift))
    else $error("result register loaded without a drain shift");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for matrix_multiply: a directed table, then random load/start jobs,
// with every result checked against a behavioral model of C = A x B or a typed-in value.
// Depends on mm_pkg and the channel interfaces in mm_if.sv.
module tb;
  import mm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 2 * (DIM_CAP + 3);
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 40;
  localparam int RANDOM_ITEMS   = 480;
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int DIRECTED_STEPS = 30;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [ELEM_W-1:0]  value;
  } command_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } product_t;

  typedef enum logic {STEP_REG, STEP_CMD} step_op_e;

  // One row of the directed table; pinned rows carry a 1x1 result typed in
  typedef struct packed {
    step_op_e                op;
    logic [CFG_IDX_W-1:0]    reg_index;
    logic [DIM_W-1:0]        reg_data;
    logic [KIND_W-1:0]       kind;
    logic [INDEX_W-1:0]      index;
    logic [ELEM_W-1:0]       value;
    logic                    pinned;
    logic signed [SUM_W-1:0] pin_value;
  } step_t;

  logic clk;
  logic rst;

  mm_cmd_if cmd_bus ();
  mm_res_if res_bus ();
  mm_cfg_if cfg_bus ();

  matrix_multiply dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_bus),
    .result(res_bus),
    .cfg   (cfg_bus)
  );

  // Model state: element stores, dimension registers, pending products
  logic signed [ELEM_W-1:0] left_model  [STORE_DEPTH];
  logic signed [ELEM_W-1:0] right_model [STORE_DEPTH];
  logic [DIM_W-1:0]         rows_cfg  = DIM_RESET;
  logic [DIM_W-1:0]         inner_cfg = DIM_RESET;
  logic [DIM_W-1:0]         cols_cfg  = DIM_RESET;
  product_t                 expected_products [$];

  // Sender bookkeeping: entries written since reset
  bit left_loaded  [STORE_DEPTH];
  bit right_loaded [STORE_DEPTH];

  step_t    plan [DIRECTED_STEPS];
  bit       pin_pending;
  product_t pinned_product;
  bit       sender_steady;
  int       errors;
  int       delivered;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Bound the run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return DIM_W'($urandom_range(9, 15));
    if (r < 26) return DIM_W'($urandom_range(5, 8));
    return DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h7FFF;
    if (r < 16) return 16'h8000;
    if (r < 20) return '0;
    return ELEM_W'($urandom);
  endfunction

  // Zero acts as one; anything past the cap acts as the cap
  function automatic int effective_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return int'(v);
  endfunction

  // Queue every element of C in row-major order
  task automatic predict_products();
    int       n, p, m, i, j, k;
    longint   acc;
    product_t pr;
    n = effective_dim(rows_cfg);
    p = effective_dim(inner_cfg);
    m = effective_dim(cols_cfg);
    for (i = 0; i < n; i++) begin
      for (j = 0; j < m; j++) begin
        acc = 0;
        for (k = 0; k < p; k++) begin
          acc += longint'(left_model[i * p + k]) * longint'(right_model[k * m + j]);
        end
        pr.value = SUM_W'(acc);
        pr.row   = POS_W'(i);
        pr.col   = POS_W'(j);
        pr.last  = (i == n - 1) && (j == m - 1);
        expected_products = {expected_products, pr};
      end
    end
  endtask

  // Watch all three channels; check results before taking new commands
  always @(posedge clk) begin : observe
    product_t want;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        delivered++;
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected result value %0d row %0d col %0d", $time,
                   res_bus.product_value, res_bus.result_row, res_bus.result_col);
          errors++;
        end else begin
          want = expected_products.pop_front();
          if (res_bus.product_value !== want.value) begin
            $display("%0t: product_value expected %0d actual %0d", $time,
                     want.value, res_bus.product_value);
            errors++;
          end
          if (res_bus.result_row !== want.row) begin
            $display("%0t: result_row expected %0d actual %0d", $time,
                     want.row, res_bus.result_row);
            errors++;
          end
          if (res_bus.result_col !== want.col) begin
            $display("%0t: result_col expected %0d actual %0d", $time,
                     want.col, res_bus.result_col);
            errors++;
          end
          if (res_bus.last_element !== want.last) begin
            $display("%0t: last_element expected %0d actual %0d", $time,
                     want.last, res_bus.last_element);
            errors++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_ROWS_LHS:  rows_cfg  = cfg_bus.data;
          CFG_INNER_DIM: inner_cfg = cfg_bus.data;
          CFG_COLS_RHS:  cols_cfg  = cfg_bus.data;
          default: ;
        endcase
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        case (cmd_bus.kind)
          KIND_LOAD_LEFT: begin
            if (cmd_bus.element_index < STORE_DEPTH)
              left_model[cmd_bus.element_index] = cmd_bus.element_value;
          end
          KIND_LOAD_RIGHT: begin
            if (cmd_bus.element_index < STORE_DEPTH)
              right_model[cmd_bus.element_index] = cmd_bus.element_value;
          end
          KIND_START: begin
            if (pin_pending) begin
              expected_products = {expected_products, pinned_product};
              pin_pending = 1'b0;
            end else begin
              predict_products();
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result side: random stalls, some long open stretches, one long hold-off
  initial begin : result_sink
    int hold_left;
    int open_left;
    bit held_long;
    res_bus.ready = 1'b0;
    hold_left = 0;
    open_left = 0;
    held_long = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_long && delivered >= HOLD_AFTER && res_bus.valid && cmd_bus.valid) begin
        held_long = 1'b1;
        hold_left = HOLD_CYCLES;
        open_left = 0;
      end
      if (hold_left == 0 && open_left == 0) begin
        hold_left = idle_len();
        open_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 10);
      end
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        res_bus.ready <= 1'b1;
        open_left--;
      end
    end
  end

  // Offer one command after an optional gap and hold it until the transfer
  task automatic issue_command(input command_t c);
    int gap;
    gap = sender_steady ? 0 : idle_len();
    if (c.kind == KIND_LOAD_LEFT) left_loaded[c.index] = 1'b1;
    if (c.kind == KIND_LOAD_RIGHT) right_loaded[c.index] = 1'b1;
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.kind          <= c.kind;
    cmd_bus.element_index <= c.index;
    cmd_bus.element_value <= c.value;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
  endtask

  // Drop the command valid and wait until every product is out and the block settles
  task automatic drain_results();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays high afterwards; the caller drops it after the last write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] rows, inner, cols);
    drain_results();
    write_register(CFG_ROWS_LHS, rows);
    write_register(CFG_INNER_DIM, inner);
    write_register(CFG_COLS_RHS, cols);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int       i, x, y, job, items_sent, n, p, m;
    command_t c;
    command_t swap;
    command_t loads [$];

    // 1x1x1 extremes with results typed in, then the dimension clamps
    plan[0]  = '{STEP_REG, CFG_ROWS_LHS,  4'd1,  KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[1]  = '{STEP_REG, CFG_INNER_DIM, 4'd1,  KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[2]  = '{STEP_REG, CFG_COLS_RHS,  4'd1,  KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[3]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_LEFT,  6'd0, 16'h7FFF, 1'b0, 40'sd0};
    plan[4]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd0, 16'h7FFF, 1'b0, 40'sd0};
    plan[5]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_START, 6'd63, 16'hFFFF, 1'b1,
                 40'sd1073676289};
    plan[6]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_LEFT,  6'd0, 16'h8000, 1'b0, 40'sd0};
    plan[7]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd0, 16'h8000, 1'b0, 40'sd0};
    plan[8]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_START, 6'd0, 16'h0, 1'b1,
                 40'sd1073741824};
    plan[9]  = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd0, 16'h7FFF, 1'b0, 40'sd0};
    plan[10] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_START, 6'd0, 16'h0, 1'b1,
                 -40'sd1073709056};
    // unused kind must leave the stores alone
    plan[11] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_UNUSED, 6'd0, 16'h1234, 1'b0, 40'sd0};
    plan[12] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_START, 6'd21, 16'h5555, 1'b1,
                 -40'sd1073709056};
    // zero rows and inner act as one, fifteen columns act as the cap
    plan[13] = '{STEP_REG, CFG_ROWS_LHS,  4'd0,  KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[14] = '{STEP_REG, CFG_INNER_DIM, 4'd0,  KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[15] = '{STEP_REG, CFG_COLS_RHS,  4'd15, KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[16] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd1, 16'h0100, 1'b0, 40'sd0};
    plan[17] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd2, 16'hFF00, 1'b0, 40'sd0};
    plan[18] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd3, 16'h0001, 1'b0, 40'sd0};
    plan[19] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd4, 16'hFFFF, 1'b0, 40'sd0};
    plan[20] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd5, 16'h4000, 1'b0, 40'sd0};
    plan[21] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd6, 16'hC000, 1'b0, 40'sd0};
    plan[22] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_RIGHT, 6'd7, 16'h7FFF, 1'b0, 40'sd0};
    plan[23] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_START, 6'd0, 16'h0, 1'b0, 40'sd0};
    // one row, inner of one, eight columns read from the already loaded stores
    plan[24] = '{STEP_REG, CFG_ROWS_LHS,  4'd1, KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[25] = '{STEP_REG, CFG_INNER_DIM, 4'd1, KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[26] = '{STEP_REG, CFG_COLS_RHS,  4'd8, KIND_UNUSED, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[27] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_LOAD_LEFT, 6'd0, 16'hFFFF, 1'b0, 40'sd0};
    plan[28] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_START, 6'd0, 16'h0, 1'b0, 40'sd0};
    plan[29] = '{STEP_CMD, CFG_ROWS_LHS, 4'd0, KIND_UNUSED, 6'd63, 16'hFFFF, 1'b0, 40'sd0};

    // Known values on every input, then reset
    rst                   = 1'b1;
    cmd_bus.valid         = 1'b0;
    cmd_bus.kind          = KIND_LOAD_LEFT;
    cmd_bus.element_index = '0;
    cmd_bus.element_value = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_ROWS_LHS;
    cfg_bus.data          = '0;
    pin_pending           = 1'b0;
    sender_steady         = 1'b0;
    errors                = 0;
    delivered             = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (i = 0; i < DIRECTED_STEPS; i++) begin
      if (plan[i].op == STEP_REG) begin
        if (i == 0 || plan[i - 1].op != STEP_REG) drain_results();
        write_register(plan[i].reg_index, plan[i].reg_data);
        if (i == DIRECTED_STEPS - 1 || plan[i + 1].op != STEP_REG) begin
          @(negedge clk);
          cfg_bus.valid <= 1'b0;
        end
      end else begin
        // Let the monitor take the previous transfer before the pin changes
        @(negedge clk);
        pin_pending          = plan[i].pinned;
        pinned_product.value = plan[i].pin_value;
        pinned_product.row   = '0;
        pinned_product.col   = '0;
        pinned_product.last  = 1'b1;
        c.kind  = plan[i].kind;
        c.index = plan[i].index;
        c.value = plan[i].value;
        issue_command(c);
      end
    end

    // Random jobs: reshape sometimes, load the operands in shuffled order, usually start
    items_sent = 0;
    job = 0;
    while (items_sent < RANDOM_ITEMS) begin
      job++;
      if (job == 2) begin
        set_dims(4'd15, 4'd15, 4'd15);
      end else if (job == 5) begin
        set_dims(DIM_RESET, DIM_RESET, DIM_RESET);
      end else if ($urandom_range(0, 99) < 35) begin
        set_dims(pick_dim(), pick_dim(), pick_dim());
      end else if (job == 8) begin
        drain_results();
      end
      sender_steady = ($urandom_range(0, 3) == 0);
      n = effective_dim(rows_cfg);
      p = effective_dim(inner_cfg);
      m = effective_dim(cols_cfg);

      // Entries never written must be loaded; others are reloaded most of the time
      loads.delete();
      for (x = 0; x < n * p; x++) begin
        if (!left_loaded[x] || $urandom_range(0, 9) < 7) begin
          c.kind  = KIND_LOAD_LEFT;
          c.index = INDEX_W'(x);
          c.value = pick_element();
          loads = {loads, c};
        end
      end
      for (x = 0; x < p * m; x++) begin
        if (!right_loaded[x] || $urandom_range(0, 9) < 7) begin
          c.kind  = KIND_LOAD_RIGHT;
          c.index = INDEX_W'(x);
          c.value = pick_element();
          loads = {loads, c};
        end
      end
      for (x = loads.size() - 1; x > 0; x--) begin
        y        = $urandom_range(0, x);
        swap     = loads[x];
        loads[x] = loads[y];
        loads[y] = swap;
      end

      // Sprinkle stray loads and unused kinds between the operand loads
      for (x = 0; x < loads.size(); x++) begin
        if ($urandom_range(0, 99) < 6) begin
          if ($urandom_range(0, 1) == 0) c.kind = KIND_UNUSED;
          else c.kind = $urandom_range(0, 1) ? KIND_LOAD_LEFT : KIND_LOAD_RIGHT;
          c.index = INDEX_W'($urandom_range(0, 63));
          c.value = ELEM_W'($urandom);
          issue_command(c);
          if (c.kind != KIND_UNUSED) items_sent++;
        end
        issue_command(loads[x]);
        items_sent++;
      end

      // Occasionally leave a job without its start
      if ($urandom_range(0, 9) != 0) begin
        c.kind  = KIND_START;
        c.index = INDEX_W'($urandom);
        c.value = ELEM_W'($urandom);
        issue_command(c);
        items_sent++;
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
